// ----- src/rlg_pkg.sv -----
// Shared types, register indexes and reset values of the resistance learning gate.
`default_nettype none
package rlg_pkg;

   localparam int HISTORY_SLOTS = 3;

   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HISTORY_DEPTH   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NOMINAL         = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT_DEV_MAX  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CROSS_DEV_MAX   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_GUARD_RATIO     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FALLBACK        = 3'd5;

   localparam logic [1:0]         DEPTH_RESET     = 2'd3;
   localparam logic [30:0]        NOMINAL_RESET   = 31'd100000;
   localparam logic [31:0]        REPEAT_RESET    = 32'd3277;
   localparam logic [31:0]        CROSS_RESET     = 32'd6554;
   localparam logic [24:0]        GUARD_RESET     = 25'd131072;
   localparam logic signed [31:0] FALLBACK_RESET  = 32'sd100000;

   localparam logic req_cmd_submit = 1'b0;
   localparam logic req_cmd_clear  = 1'b1;

   typedef struct packed {
      logic [1:0]         depth;
      logic [30:0]        nominal;
      logic [31:0]        repeat_max;
      logic [31:0]        cross_max;
      logic [24:0]        guard;
      logic signed [31:0] fallback;
   } cfg_type;

   typedef struct packed {
      logic               command;
      logic signed [31:0] static_resistance;
      logic               static_trusted;
      logic signed [31:0] dynamic_resistance;
      logic               dynamic_valid;
   } item_type;

   typedef struct packed {
      logic               full;
      logic signed [31:0] median;
      logic [31:0]        mad;
   } hist_type;

   typedef struct packed {
      logic adopted;
      logic repeat_fail;
      logic cross_fail;
      logic guard_fail;
      logic learned;
   } flags_type;

endpackage
`default_nettype wire

// ----- src/rlg_history.sv -----
// Three-slot measurement history with push, median and median absolute deviation.
`default_nettype none
module rlg_history (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                commit,
   input  wire logic                clear,
   input  wire logic                push,
   input  wire logic [1:0]          depth,
   input  wire logic signed [31:0]  sample,
   output rlg_pkg::hist_type        hist
);

   logic signed [31:0] slot_ff [rlg_pkg::HISTORY_SLOTS];
   logic signed [31:0] slot_in [rlg_pkg::HISTORY_SLOTS];
   logic [31:0]        dev [rlg_pkg::HISTORY_SLOTS];
   logic [1:0]         fill_ff;
   logic [1:0]         fill_in;
   logic               full_old;
   logic [1:0]         base;
   logic signed [31:0] lo;
   logic signed [31:0] hi;
   logic signed [31:0] med;
   logic [31:0]        dlo;
   logic [31:0]        dhi;
   logic [31:0]        mad;
   logic signed [32:0] diff [rlg_pkg::HISTORY_SLOTS];
   logic signed [32:0] mag [rlg_pkg::HISTORY_SLOTS];

   // When the window is full the oldest entry drops out and the sample lands at depth-1.
   always_comb begin
      full_old = (fill_ff >= depth);
      base     = full_old ? (depth - 2'd1) : fill_ff;
      for (int i = 0; i < rlg_pkg::HISTORY_SLOTS; i++) begin
         slot_in[i] = slot_ff[i];
      end
      for (int i = 0; i < rlg_pkg::HISTORY_SLOTS - 1; i++) begin
         if (full_old && (2'(i + 1) < depth)) begin
            slot_in[i] = slot_ff[i + 1];
         end
      end
      for (int i = 0; i < rlg_pkg::HISTORY_SLOTS; i++) begin
         if (2'(i) == base) begin
            slot_in[i] = sample;
         end
      end
      fill_in = base + 2'd1;
   end

   always_comb begin
      lo  = (slot_in[0] < slot_in[1]) ? slot_in[0] : slot_in[1];
      hi  = (slot_in[0] < slot_in[1]) ? slot_in[1] : slot_in[0];
      med = (slot_in[2] < lo) ? lo : ((slot_in[2] > hi) ? hi : slot_in[2]);
      for (int i = 0; i < rlg_pkg::HISTORY_SLOTS; i++) begin
         diff[i] = {slot_in[i][31], slot_in[i]} - {med[31], med};
         mag[i]  = diff[i][32] ? -diff[i] : diff[i];
         dev[i]  = mag[i][31:0];
      end
      dlo = (dev[0] < dev[1]) ? dev[0] : dev[1];
      dhi = (dev[0] < dev[1]) ? dev[1] : dev[0];
      mad = (dev[2] < dlo) ? dlo : ((dev[2] > dhi) ? dhi : dev[2]);
      hist.full   = (fill_in == depth);
      hist.median = med;
      hist.mad    = mad;
   end

   always_ff @(posedge clock) begin
      if (reset || (commit && clear)) begin
         fill_ff <= 2'd0;
         for (int i = 0; i < rlg_pkg::HISTORY_SLOTS; i++) begin
            slot_ff[i] <= 32'sd0;
         end
      end else if (commit && push) begin
         fill_ff <= fill_in;
         for (int i = 0; i < rlg_pkg::HISTORY_SLOTS; i++) begin
            slot_ff[i] <= slot_in[i];
         end
      end
   end

endmodule
`default_nettype wire

// ----- src/rlg_gates.sv -----
// Deviation, cross-source and guard band gates, plus the guard check of the held value.
`default_nettype none
module rlg_gates (
   input  wire rlg_pkg::cfg_type    cfg,
   input  wire rlg_pkg::item_type   item,
   input  wire rlg_pkg::hist_type   hist,
   input  wire logic                push,
   input  wire logic [55:0]         nom_guard,
   input  wire logic                held_valid,
   input  wire logic signed [31:0]  held_value,
   output rlg_pkg::flags_type       flags,
   output logic                     held_ok
);

   logic signed [31:0] med;
   logic signed [31:0] s_val;
   logic signed [31:0] d_val;
   logic               med_pos;
   logic               held_pos;
   logic [63:0]        rep_rhs;
   logic [63:0]        cross_rhs;
   logic signed [32:0] cdiff;
   logic signed [32:0] cmag;
   logic               mad_gt;
   logic               cross_bad;
   logic               guard_out;
   logic               pass_repeat;
   logic               pass_cross;

   // True when r lies outside [nominal / guard, nominal * guard]; r is positive here.
   function automatic logic outside_guard(input logic [30:0] r, input logic [30:0] nom,
                                          input logic [24:0] guard, input logic [55:0] hi);
      logic [55:0] r_up;
      logic [55:0] r_scaled;
      logic [55:0] lo;
      r_up     = 56'({r, 16'd0});
      r_scaled = 56'(r) * 56'(guard);
      lo       = 56'({nom, 16'd0});
      return (r_up > hi) || (r_scaled < lo);
   endfunction

   always_comb begin
      med      = hist.median;
      s_val    = item.static_resistance;
      d_val    = item.dynamic_resistance;
      med_pos  = !med[31] && (med != 32'sd0);
      held_pos = !held_value[31] && (held_value != 32'sd0);

      rep_rhs = 64'(cfg.repeat_max) * 64'(med[31:0]);
      mad_gt  = 64'({hist.mad, 16'd0}) > rep_rhs;

      cdiff     = {d_val[31], d_val} - {s_val[31], s_val};
      cmag      = cdiff[32] ? -cdiff : cdiff;
      cross_rhs = 64'(cfg.cross_max) * 64'(s_val[31:0]);
      cross_bad = !item.dynamic_valid || d_val[31] || (d_val == 32'sd0)
                  || (64'({cmag[31:0], 16'd0}) > cross_rhs);

      guard_out = outside_guard(med[30:0], cfg.nominal, cfg.guard, nom_guard);

      pass_repeat = hist.full && med_pos && !mad_gt;
      pass_cross  = pass_repeat && !cross_bad;

      flags.adopted     = push;
      flags.repeat_fail = push && !pass_repeat;
      flags.cross_fail  = push && pass_repeat && cross_bad;
      flags.guard_fail  = push && pass_cross && guard_out;
      flags.learned     = push && pass_cross && !guard_out;

      held_ok = held_valid && held_pos
                && !outside_guard(held_value[30:0], cfg.nominal, cfg.guard, nom_guard);
   end

endmodule
`default_nettype wire

// ----- src/resistance_learning_gate.sv -----
// Top level of the resistance learning gate: handshakes, registers and learned state.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  command, static and dynamic measurement
//   rsp      out        rsp_valid/rsp_stall  gate flags, learned state, effective value
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// An accepted beat lands in the input register and is evaluated against the history and
// held state from there, landing in the result register when that register is free to
// take it; one item per cycle sustained while rsp is not stalled. The history push,
// median and gates form one pass.
// Reset restores the register defaults and clears history and learned state.
// A stalled result holds the result register; a full input register then stalls req.
`default_nettype none
module resistance_learning_gate (
   input  wire logic                clock,
   input  wire logic                reset,

   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_command,
   input  wire logic signed [31:0]  req_static_resistance,
   input  wire logic                req_static_trusted,
   input  wire logic signed [31:0]  req_dynamic_resistance,
   input  wire logic                req_dynamic_valid,

   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_adopted,
   output logic                     rsp_repeat_fail,
   output logic                     rsp_cross_fail,
   output logic                     rsp_guard_fail,
   output logic                     rsp_learned,
   output logic                     rsp_learned_valid_out,
   output logic signed [31:0]       rsp_learned_value,
   output logic [31:0]              rsp_learn_revision,
   output logic signed [31:0]       rsp_effective_resistance,

   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [rlg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [31:0]         csr_data
);

   rlg_pkg::cfg_type   cfg_ff;
   logic [55:0]        nom_guard_ff;
   rlg_pkg::item_type  item_ff;
   logic               item_valid_ff;
   logic               out_ready;
   logic               commit;
   logic               clear;
   logic               push;
   rlg_pkg::hist_type  hist;
   rlg_pkg::flags_type flags;
   logic               held_ok;
   logic               held_valid_ff;
   logic               held_valid_in;
   logic signed [31:0] held_ff;
   logic signed [31:0] held_in;
   logic [31:0]        rev_ff;
   logic [31:0]        rev_in;
   logic signed [31:0] eff_in;

   rlg_pkg::flags_type flags_ff;
   logic               rsp_valid_ff;
   logic               out_held_valid_ff;
   logic signed [31:0] out_held_ff;
   logic [31:0]        out_rev_ff;
   logic signed [31:0] out_eff_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.depth      <= rlg_pkg::DEPTH_RESET;
         cfg_ff.nominal    <= rlg_pkg::NOMINAL_RESET;
         cfg_ff.repeat_max <= rlg_pkg::REPEAT_RESET;
         cfg_ff.cross_max  <= rlg_pkg::CROSS_RESET;
         cfg_ff.guard      <= rlg_pkg::GUARD_RESET;
         cfg_ff.fallback   <= rlg_pkg::FALLBACK_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rlg_pkg::CSR_HISTORY_DEPTH:  cfg_ff.depth      <= csr_data[1:0];
            rlg_pkg::CSR_NOMINAL:        cfg_ff.nominal    <= csr_data[30:0];
            rlg_pkg::CSR_REPEAT_DEV_MAX: cfg_ff.repeat_max <= csr_data;
            rlg_pkg::CSR_CROSS_DEV_MAX:  cfg_ff.cross_max  <= csr_data;
            rlg_pkg::CSR_GUARD_RATIO:    cfg_ff.guard      <= csr_data[24:0];
            rlg_pkg::CSR_FALLBACK:       cfg_ff.fallback   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Upper guard limit, refreshed every cycle so it tracks the last register write.
   always_ff @(posedge clock) begin
      nom_guard_ff <= 56'(cfg_ff.nominal) * 56'(cfg_ff.guard);
   end

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign commit    = item_valid_ff && out_ready;
   assign req_stall = item_valid_ff && !out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (!item_valid_ff || out_ready) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff.command            <= req_command;
         item_ff.static_resistance  <= req_static_resistance;
         item_ff.static_trusted     <= req_static_trusted;
         item_ff.dynamic_resistance <= req_dynamic_resistance;
         item_ff.dynamic_valid      <= req_dynamic_valid;
      end
   end

   assign clear = (item_ff.command == rlg_pkg::req_cmd_clear);
   assign push  = (item_ff.command == rlg_pkg::req_cmd_submit)
                  && (cfg_ff.depth != 2'd0) && (cfg_ff.nominal != 31'd0)
                  && item_ff.static_trusted && !item_ff.static_resistance[31]
                  && (item_ff.static_resistance != 32'sd0);

   rlg_history u_history (
      .clock  (clock),
      .reset  (reset),
      .commit (commit),
      .clear  (clear),
      .push   (push),
      .depth  (cfg_ff.depth),
      .sample (item_ff.static_resistance),
      .hist   (hist)
   );

   rlg_gates u_gates (
      .cfg        (cfg_ff),
      .item       (item_ff),
      .hist       (hist),
      .push       (push),
      .nom_guard  (nom_guard_ff),
      .held_valid (held_valid_ff),
      .held_value (held_ff),
      .flags      (flags),
      .held_ok    (held_ok)
   );

   // A freshly learned median already passed the guard, so it is the effective value.
   always_comb begin
      held_valid_in = held_valid_ff;
      held_in       = held_ff;
      rev_in        = rev_ff;
      eff_in        = held_ok ? held_ff : cfg_ff.fallback;
      if (clear) begin
         held_valid_in = 1'b0;
         held_in       = 32'sd0;
         rev_in        = 32'd0;
         eff_in        = cfg_ff.fallback;
      end else if (flags.learned) begin
         held_valid_in = 1'b1;
         held_in       = hist.median;
         rev_in        = rev_ff + 32'd1;
         eff_in        = hist.median;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         held_ff       <= 32'sd0;
         rev_ff        <= 32'd0;
      end else if (commit) begin
         held_valid_ff <= held_valid_in;
         held_ff       <= held_in;
         rev_ff        <= rev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         flags_ff          <= clear ? '0 : flags;
         out_held_valid_ff <= held_valid_in;
         out_held_ff       <= held_in;
         out_rev_ff        <= rev_in;
         out_eff_ff        <= eff_in;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_adopted              = flags_ff.adopted;
   assign rsp_repeat_fail          = flags_ff.repeat_fail;
   assign rsp_cross_fail           = flags_ff.cross_fail;
   assign rsp_guard_fail           = flags_ff.guard_fail;
   assign rsp_learned              = flags_ff.learned;
   assign rsp_learned_valid_out    = out_held_valid_ff;
   assign rsp_learned_value        = out_held_ff;
   assign rsp_learn_revision       = out_rev_ff;
   assign rsp_effective_resistance = out_eff_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_repeat_fail, rsp_cross_fail, rsp_guard_fail, rsp_learned}))
      else $error("more than one gate outcome in a result beat");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_learned |-> rsp_adopted && rsp_learned_valid_out
                                   && (rsp_effective_resistance == rsp_learned_value))
      else $error("learned result does not show the new value");

   assert property (@(posedge clock) disable iff (reset)
      commit && !clear && flags.learned |=> rev_ff == $past(rev_ff) + 32'd1)
      else $error("revision count did not advance on a learning update");

   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> item_valid_ff && rsp_valid_ff)
      else $error("input stalled with no result waiting");

endmodule
`default_nettype wire
